// ----- src/assert_macros.svh -----
// Assertion macros used by attc_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ----- src/attc_pkg.sv -----
`timescale 1ns / 1ps

package attc_pkg;

    localparam int MAX_PARAMS_DEF = 10;
    localparam int TAB_STOP_DEF   = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam int DIM_W      = 9;
    localparam int PARAM_W    = 10;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 1'd1;

    localparam logic [DIM_W-1:0] COLUMNS_RESET = 9'd80;
    localparam logic [DIM_W-1:0] ROWS_RESET    = 9'd25;
    localparam logic [DIM_W-1:0] DIM_MAX       = 9'd256;

    localparam logic [3:0] FG_RESET = 4'd7;
    localparam logic [3:0] BG_RESET = 4'd0;

    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [PARAM_W-1:0] SGR_FG_LO = 10'd30;
    localparam logic [PARAM_W-1:0] SGR_FG_HI = 10'd37;
    localparam logic [PARAM_W-1:0] SGR_BG_LO = 10'd40;
    localparam logic [PARAM_W-1:0] SGR_BG_HI = 10'd47;
    localparam logic [PARAM_W-1:0] PARAM_SAT = 10'd1023;

    typedef enum logic [1:0] {
        PH_READY,
        PH_CMD,
        PH_PARAM
    } phase_t;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_NEWLINE,
        OP_TAB,
        OP_CLEAR
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] glyph;
        logic [3:0] fg;
        logic [3:0] bg;
    } op_t;

    function automatic logic [PARAM_W-1:0] add_digit(logic [PARAM_W-1:0] v,
                                                     logic [3:0] d);
        logic [13:0] n;
        n = (14'(v) << 3) + (14'(v) << 1) + 14'(d);
        return (n > 14'(PARAM_SAT)) ? PARAM_SAT : n[PARAM_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
        if (v == '0) begin
            return 9'd1;
        end
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

endpackage

// ----- src/attc_front.sv -----
`timescale 1ns / 1ps

module attc_front #(
    parameter int MAX_PARAMS = attc_pkg::MAX_PARAMS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      byte_in,
    output logic            push_valid,
    input  logic            push_ready,
    output attc_pkg::op_t   push_op
);

    localparam int CNT_W = $clog2(MAX_PARAMS + 1);

    attc_pkg::phase_t phase_reg, phase_next;
    logic [attc_pkg::PARAM_W-1:0] first_reg, first_next;
    logic [attc_pkg::PARAM_W-1:0] second_reg, second_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0] fg_reg, fg_next;
    logic [3:0] bg_reg, bg_next;

    logic accept;
    logic is_digit;
    logic as_char;
    logic do_clear;
    logic bright;
    logic [3:0] digit;
    logic [attc_pkg::PARAM_W-1:0] sgr_off;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign is_digit = byte_in inside {[attc_pkg::CH_ZERO:attc_pkg::CH_NINE]};
    assign digit    = 4'(byte_in - attc_pkg::CH_ZERO);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                attc_pkg::PH_READY:
                begin
                    phase_next = (byte_in == attc_pkg::CH_ESC) ?
                                 attc_pkg::PH_CMD : attc_pkg::PH_READY;
                end
                attc_pkg::PH_CMD:
                begin
                    phase_next = (byte_in == attc_pkg::CH_LBRK) ?
                                 attc_pkg::PH_PARAM : attc_pkg::PH_READY;
                end
                attc_pkg::PH_PARAM:
                begin
                    phase_next = (byte_in == attc_pkg::CH_SEMI || is_digit) ?
                                 attc_pkg::PH_PARAM : attc_pkg::PH_READY;
                end
                default:
                begin
                    phase_next = attc_pkg::PH_READY;
                end
            endcase
        end
    end

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        count_next  = count_reg;
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        as_char     = 1'b0;
        do_clear    = 1'b0;
        bright      = (count_reg == CNT_W'(2)) && (second_reg == 10'd1);
        sgr_off     = '0;
        case (phase_reg)
            attc_pkg::PH_READY:
            begin
                if (byte_in != attc_pkg::CH_ESC)
                begin
                    count_next = '0;
                    as_char    = 1'b1;
                end
            end
            attc_pkg::PH_CMD:
            begin
                if (byte_in == attc_pkg::CH_LBRK)
                begin
                    count_next = CNT_W'(1);
                    first_next = '0;
                end
                else
                begin
                    count_next = '0;
                    do_clear   = (byte_in == attc_pkg::CH_C);
                    as_char    = !do_clear;
                end
            end
            attc_pkg::PH_PARAM:
            begin
                if (byte_in == attc_pkg::CH_SEMI)
                begin
                    if (count_reg < CNT_W'(MAX_PARAMS))
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            second_next = '0;
                        end
                    end
                end
                else if (byte_in == attc_pkg::CH_M)
                begin
                    count_next = '0;
                    if (first_reg == '0)
                    begin
                        fg_next = attc_pkg::FG_RESET;
                        bg_next = attc_pkg::BG_RESET;
                    end
                    else if (first_reg >= attc_pkg::SGR_FG_LO &&
                             first_reg <= attc_pkg::SGR_FG_HI)
                    begin
                        sgr_off = first_reg - attc_pkg::SGR_FG_LO;
                        fg_next = {bright, sgr_off[2:0]};
                    end
                    else if (first_reg >= attc_pkg::SGR_BG_LO &&
                             first_reg <= attc_pkg::SGR_BG_HI)
                    begin
                        sgr_off = first_reg - attc_pkg::SGR_BG_LO;
                        bg_next = {bright, sgr_off[2:0]};
                    end
                end
                else if (is_digit)
                begin
                    if (count_reg <= CNT_W'(1))
                    begin
                        first_next = attc_pkg::add_digit(first_reg, digit);
                    end
                    else if (count_reg == CNT_W'(2))
                    begin
                        second_next = attc_pkg::add_digit(second_reg, digit);
                    end
                end
                else
                begin
                    count_next = '0;
                    as_char    = 1'b1;
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase

        push_op.glyph = byte_in;
        push_op.fg    = fg_reg;
        push_op.bg    = bg_reg;
        if (do_clear)
        begin
            push_op.kind = attc_pkg::OP_CLEAR;
        end
        else if (byte_in == attc_pkg::CH_LF)
        begin
            push_op.kind = attc_pkg::OP_NEWLINE;
        end
        else if (byte_in == attc_pkg::CH_TAB)
        begin
            push_op.kind = attc_pkg::OP_TAB;
        end
        else
        begin
            push_op.kind = attc_pkg::OP_DRAW;
        end
        push_valid = accept && (do_clear || (as_char && byte_in != attc_pkg::CH_NUL));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= attc_pkg::PH_READY;
            first_reg  <= '0;
            second_reg <= '0;
            count_reg  <= '0;
            fg_reg     <= attc_pkg::FG_RESET;
            bg_reg     <= attc_pkg::BG_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            if (accept)
            begin
                first_reg  <= first_next;
                second_reg <= second_next;
                count_reg  <= count_next;
                fg_reg     <= fg_next;
                bg_reg     <= bg_next;
            end
        end
    end

endmodule

// ----- src/attc_queue.sv -----
`timescale 1ns / 1ps

module attc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  attc_pkg::op_t push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output attc_pkg::op_t pop_op
);

    localparam int PTR_W = (attc_pkg::QUEUE_DEPTH > 1) ? $clog2(attc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(attc_pkg::QUEUE_DEPTH + 1);

    attc_pkg::op_t entry_reg [attc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg < CNT_W'(attc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(attc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(attc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/attc_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module attc_back #(
    parameter int TAB_STOP = attc_pkg::TAB_STOP_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [attc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [attc_pkg::DIM_W-1:0]       cfg_data,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  attc_pkg::op_t                    pop_op,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       command,
    output logic [7:0]                       glyph,
    output logic [7:0]                       column,
    output logic [7:0]                       row,
    output logic [3:0]                       fore_index,
    output logic [3:0]                       back_index,
    output logic                             last
);

    localparam int DW    = attc_pkg::DIM_W;
    localparam int PH_W  = $clog2(TAB_STOP);

    logic [DW-1:0] columns_reg;
    logic [DW-1:0] rows_reg;
    logic [DW-1:0] col_reg, col_next;
    logic [DW-1:0] row_reg, row_next;
    logic [PH_W-1:0] tab_ph_reg, tab_ph_next;

    logic       out_valid_reg, out_valid_next;
    logic       pend_reg, pend_next;
    logic [3:0] pend_back_reg, pend_back_next;
    logic [1:0] cmd_reg, cmd_next;
    logic [7:0] glyph_reg, glyph_next;
    logic [7:0] column_reg, column_next;
    logic [7:0] row_out_reg, row_out_next;
    logic [3:0] fore_reg, fore_next;
    logic [3:0] back_reg, back_next;
    logic       last_reg, last_next;

    logic [DW-1:0] ncol;
    logic [DW-1:0] nrow;
    logic take;
    logic is_draw;
    logic is_clear;
    logic scroll;
    logic has_r0;
    logic has_r1;
    logic pend_leaving;
    logic scroll_shown;

    assign cfg_ready  = 1'b1;
    assign ncol       = attc_pkg::clamp_dim(columns_reg);
    assign nrow       = attc_pkg::clamp_dim(rows_reg);
    assign take       = pop_valid && (!out_valid_reg || (out_ready && !pend_reg));
    assign pop_ready  = take;
    assign is_draw    = (pop_op.kind == attc_pkg::OP_DRAW);
    assign is_clear   = (pop_op.kind == attc_pkg::OP_CLEAR);

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        tab_ph_next = tab_ph_reg;
        case (pop_op.kind)
            attc_pkg::OP_DRAW:
            begin
                col_next    = col_reg + DW'(1);
                tab_ph_next = (tab_ph_reg == PH_W'(TAB_STOP - 1)) ?
                              '0 : tab_ph_reg + PH_W'(1);
            end
            attc_pkg::OP_NEWLINE:
            begin
                col_next    = '0;
                row_next    = row_reg + DW'(1);
                tab_ph_next = '0;
            end
            attc_pkg::OP_TAB:
            begin
                if (tab_ph_reg != '0)
                begin
                    col_next = col_reg + DW'(TAB_STOP) - DW'(tab_ph_reg);
                end
                tab_ph_next = '0;
            end
            attc_pkg::OP_CLEAR:
            begin
                col_next    = '0;
                row_next    = '0;
                tab_ph_next = '0;
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
        if (col_next >= ncol)
        begin
            col_next    = '0;
            row_next    = row_next + DW'(1);
            tab_ph_next = '0;
        end
        scroll = (row_next >= nrow);
        if (scroll)
        begin
            row_next = nrow - DW'(1);
        end
        has_r0 = is_draw || is_clear || scroll;
        has_r1 = is_draw && scroll;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        pend_back_next = pend_back_reg;
        cmd_next       = cmd_reg;
        glyph_next     = glyph_reg;
        column_next    = column_reg;
        row_out_next   = row_out_reg;
        fore_next      = fore_reg;
        back_next      = back_reg;
        last_next      = last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = pend_reg;
            pend_next      = 1'b0;
            cmd_next       = attc_pkg::CMD_SCROLL;
            glyph_next     = '0;
            column_next    = '0;
            row_out_next   = '0;
            fore_next      = '0;
            back_next      = pend_back_reg;
            last_next      = 1'b1;
        end
        if (take && has_r0)
        begin
            out_valid_next = 1'b1;
            pend_next      = has_r1;
            pend_back_next = pop_op.bg;
            back_next      = pop_op.bg;
            last_next      = !has_r1;
            if (is_draw)
            begin
                cmd_next     = attc_pkg::CMD_DRAW;
                glyph_next   = pop_op.glyph;
                column_next  = col_reg[7:0];
                row_out_next = row_reg[7:0];
                fore_next    = pop_op.fg;
            end
            else
            begin
                cmd_next     = is_clear ? attc_pkg::CMD_CLEAR : attc_pkg::CMD_SCROLL;
                glyph_next   = '0;
                column_next  = '0;
                row_out_next = '0;
                fore_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= attc_pkg::COLUMNS_RESET;
            rows_reg      <= attc_pkg::ROWS_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            tab_ph_reg    <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == attc_pkg::REG_COLUMNS)
                begin
                    columns_reg <= cfg_data;
                end
                else if (cfg_index == attc_pkg::REG_ROWS)
                begin
                    rows_reg <= cfg_data;
                end
            end
            if (take)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                tab_ph_reg <= tab_ph_next;
            end
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_back_reg <= pend_back_next;
        cmd_reg       <= cmd_next;
        glyph_reg     <= glyph_next;
        column_reg    <= column_next;
        row_out_reg   <= row_out_next;
        fore_reg      <= fore_next;
        back_reg      <= back_next;
        last_reg      <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign command    = cmd_reg;
    assign glyph      = glyph_reg;
    assign column     = column_reg;
    assign row        = row_out_reg;
    assign fore_index = fore_reg;
    assign back_index = back_reg;
    assign last       = last_reg;

    assign pend_leaving = out_valid_reg && out_ready && pend_reg;
    assign scroll_shown = out_valid_reg && (cmd_reg == attc_pkg::CMD_SCROLL) && last_reg;

    `ASSERT_CLK(a_pend_needs_out, clk, rst_n, pend_reg |-> out_valid_reg)
    `ASSERT_NEVER(a_col_in_range, clk, rst_n, col_reg[DW-1])
    `ASSERT_NEVER(a_row_in_range, clk, rst_n, row_reg[DW-1])
    `ASSERT_CLK(a_pend_is_scroll, clk, rst_n, pend_leaving |=> scroll_shown)

endmodule

// ----- src/ansi_text_terminal_controller.sv -----
`timescale 1ns / 1ps

// Character-level ANSI text terminal: takes one byte per transfer, parses ESC c
// and ESC [ ... m color sequences, tracks the cursor, and emits draw, scroll and
// clear commands one per output transfer. A parser accepts one byte every cycle
// into a two-entry queue while it has room, and the cursor unit takes one queued
// byte per cycle while the output register is free or being taken, so the rate
// is one byte per cycle for bytes with at most one result; a byte that draws and
// scrolls holds off the next byte until its scroll leaves the output register,
// which delivers one result per cycle while out_ready is high. A result passes
// through a queue entry and then the output register before it is presented.
module ansi_text_terminal_controller #(
    parameter int MAX_PARAMS = attc_pkg::MAX_PARAMS_DEF,
    parameter int TAB_STOP   = attc_pkg::TAB_STOP_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [attc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [attc_pkg::DIM_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       byte_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       command,
    output logic [7:0]                       glyph,
    output logic [7:0]                       column,
    output logic [7:0]                       row,
    output logic [3:0]                       fore_index,
    output logic [3:0]                       back_index,
    output logic                             last
);

    logic          push_valid;
    logic          push_ready;
    attc_pkg::op_t push_op;
    logic          pop_valid;
    logic          pop_ready;
    attc_pkg::op_t pop_op;

    attc_front #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    attc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    attc_back #(
        .TAB_STOP(TAB_STOP)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .command    (command),
        .glyph      (glyph),
        .column     (column),
        .row        (row),
        .fore_index (fore_index),
        .back_index (back_index),
        .last       (last)
    );

endmodule
